// ===== rtl/sniffer_encap_option_parser_assert.svh =====
// Assertion macros used by the parser module sncap_parse.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef SNIFFER_ENCAP_OPTION_PARSER_ASSERT_SVH
`define SNIFFER_ENCAP_OPTION_PARSER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SNCAP_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sncap assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SNCAP_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sncap assertion failed");

`endif

// ===== rtl/sncap_pkg.sv =====
`default_nettype none

package sncap_pkg;

    localparam logic [1:0] StatGood   = 2'd0;
    localparam logic [1:0] StatUndecr = 2'd1;
    localparam logic [1:0] StatFcs    = 2'd2;
    localparam logic [1:0] StatNoEnd  = 2'd3;

    localparam logic [7:0] TagPad     = 8'd0;
    localparam logic [7:0] TagEnd     = 8'd1;
    localparam logic [7:0] TagSignal  = 8'd10;
    localparam logic [7:0] TagNoise   = 8'd11;
    localparam logic [7:0] TagRate    = 8'd12;
    localparam logic [7:0] TagTime    = 8'd13;
    localparam logic [7:0] TagKind    = 8'd14;
    localparam logic [7:0] TagCf      = 8'd15;
    localparam logic [7:0] TagUndecr  = 8'd16;
    localparam logic [7:0] TagFcs     = 8'd17;
    localparam logic [7:0] TagChannel = 8'd18;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  version;
        logic [15:0] encap_code;
        logic [7:0]  signal_level;
        logic [7:0]  noise_level;
        logic [7:0]  data_rate;
        logic [31:0] timestamp_us;
        logic [7:0]  frame_kind;
        logic        cf_period;
        logic [7:0]  channel_number;
        logic [8:0]  present_mask;
        logic        undecrypted;
        logic        fcs_bad;
    } t_capture;

    typedef struct packed {
        logic [7:0]  version;
        logic [15:0] encap_code;
        logic [7:0]  signal_level;
        logic [7:0]  noise_level;
        logic [7:0]  data_rate;
        logic [31:0] timestamp_us;
        logic [7:0]  frame_kind;
        logic        cf_period;
        logic [7:0]  channel_number;
        logic [8:0]  present_mask;
        logic [15:0] payload_offset;
        logic [1:0]  frame_status;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/sncap_if.sv =====
`default_nettype none

interface sncap_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;

    modport source(output valid, output data_byte, output first_byte, output last_byte,
                   input ready);
    modport sink(input valid, input data_byte, input first_byte, input last_byte,
                 output ready);
endinterface

interface sncap_res_if;
    logic        valid;
    logic        ready;
    logic [7:0]  version;
    logic [15:0] encap_code;
    logic [7:0]  signal_level;
    logic [7:0]  noise_level;
    logic [7:0]  data_rate;
    logic [31:0] timestamp_us;
    logic [7:0]  frame_kind;
    logic        cf_period;
    logic [7:0]  channel_number;
    logic [8:0]  present_mask;
    logic [15:0] payload_offset;
    logic [1:0]  frame_status;

    modport source(output valid, input ready,
                   output version, output encap_code, output signal_level,
                   output noise_level, output data_rate, output timestamp_us,
                   output frame_kind, output cf_period, output channel_number,
                   output present_mask, output payload_offset, output frame_status);
    modport sink(input valid, output ready,
                 input version, input encap_code, input signal_level,
                 input noise_level, input data_rate, input timestamp_us,
                 input frame_kind, input cf_period, input channel_number,
                 input present_mask, input payload_offset, input frame_status);
endinterface

`default_nettype wire

// ===== rtl/sncap_in_reg.sv =====
`default_nettype none

module sncap_in_reg (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    sncap_byte_if.sink         i_byte,
    input  wire logic          i_take,
    output logic               o_vld,
    output sncap_pkg::t_in_item o_item
);

    logic                r_vld;
    logic                n_vld;
    sncap_pkg::t_in_item r_item;
    logic                accept;

    assign i_byte.ready = !r_vld || i_take;
    assign accept       = i_byte.valid && i_byte.ready;

    always_comb begin
        n_vld = r_vld;
        if (accept) begin
            n_vld = 1'b1;
        end else if (i_take) begin
            n_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item.data_byte  <= i_byte.data_byte;
            r_item.first_byte <= i_byte.first_byte;
            r_item.last_byte  <= i_byte.last_byte;
        end
    end

    assign o_vld  = r_vld;
    assign o_item = r_item;

endmodule

`default_nettype wire

// ===== rtl/sncap_parse.sv =====
`default_nettype none

`include "sniffer_encap_option_parser_assert.svh"

module sncap_parse #(
    parameter int POSITION_BITS = 16
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_step,
    input  sncap_pkg::t_in_item i_item,
    output logic                o_fire,
    output sncap_pkg::t_result  o_result
);

    localparam logic [2:0] PhIdle   = 3'd0;
    localparam logic [2:0] PhHeader = 3'd1;
    localparam logic [2:0] PhTag    = 3'd2;
    localparam logic [2:0] PhLen    = 3'd3;
    localparam logic [2:0] PhValue  = 3'd4;

    localparam logic [3:0] IdxSignal  = 4'd0;
    localparam logic [3:0] IdxNoise   = 4'd1;
    localparam logic [3:0] IdxRate    = 4'd2;
    localparam logic [3:0] IdxTime    = 4'd3;
    localparam logic [3:0] IdxKind    = 4'd4;
    localparam logic [3:0] IdxCf      = 4'd5;
    localparam logic [3:0] IdxUndecr  = 4'd6;
    localparam logic [3:0] IdxFcs     = 4'd7;
    localparam logic [3:0] IdxChannel = 4'd8;
    localparam logic [3:0] IdxLast    = 4'd8;

    localparam logic [POSITION_BITS-1:0] PosMax = '1;

    logic [2:0]               r_phase, n_phase;
    logic [POSITION_BITS-1:0] r_pos, n_pos, here;
    logic [3:0]               r_tag, n_tag;
    logic [7:0]               r_left, n_left;
    logic [1:0]               r_vidx, n_vidx;
    logic                     r_cdone, n_cdone;
    sncap_pkg::t_capture      r_cap, n_cap;
    logic                     ended;
    logic [1:0]               status;
    logic [15:0]              offset;
    logic [7:0]               b;

    assign b = i_item.data_byte;

    always_comb begin
        n_phase = r_phase;
        n_pos   = r_pos;
        n_tag   = r_tag;
        n_left  = r_left;
        n_vidx  = r_vidx;
        n_cdone = r_cdone;
        n_cap   = r_cap;
        here    = r_pos;
        ended   = 1'b0;
        o_fire  = 1'b0;
        status  = sncap_pkg::StatGood;
        if (i_step) begin
            if (i_item.first_byte) begin
                n_phase = PhHeader;
                n_pos   = '0;
                n_tag   = '0;
                n_left  = '0;
                n_vidx  = '0;
                n_cdone = 1'b0;
                n_cap   = '0;
            end
            if (n_phase != PhIdle) begin
                here = n_pos;
                if (n_pos != PosMax) begin
                    n_pos = n_pos + 1'b1;
                end
                unique case (n_phase)
                    PhHeader: begin
                        if (here == POSITION_BITS'(0)) begin
                            n_cap.version = b;
                        end else if (here == POSITION_BITS'(2)) begin
                            n_cap.encap_code[15:8] = b;
                        end else if (here == POSITION_BITS'(3)) begin
                            n_cap.encap_code[7:0] = b;
                            n_phase = PhTag;
                        end
                    end
                    PhTag: begin
                        if (b == sncap_pkg::TagEnd) begin
                            ended = 1'b1;
                        end else if (b >= sncap_pkg::TagSignal &&
                                     b <= sncap_pkg::TagChannel) begin
                            n_tag = 4'(b - sncap_pkg::TagSignal);
                            n_cap.present_mask[n_tag] = 1'b1;
                            n_phase = PhLen;
                            case (n_tag)
                                IdxSignal:  n_cap.signal_level   = '0;
                                IdxNoise:   n_cap.noise_level    = '0;
                                IdxRate:    n_cap.data_rate      = '0;
                                IdxTime:    n_cap.timestamp_us   = '0;
                                IdxKind:    n_cap.frame_kind     = '0;
                                IdxCf:      n_cap.cf_period      = 1'b0;
                                IdxUndecr:  n_cap.undecrypted    = 1'b0;
                                IdxFcs:     n_cap.fcs_bad        = 1'b0;
                                IdxChannel: n_cap.channel_number = '0;
                                default: ;
                            endcase
                        end
                    end
                    PhLen: begin
                        n_left  = b;
                        n_vidx  = '0;
                        n_cdone = 1'b0;
                        n_phase = (b == 8'd0) ? PhTag : PhValue;
                    end
                    PhValue: begin
                        if (!n_cdone) begin
                            if (n_tag == IdxTime) begin
                                n_cap.timestamp_us[{~n_vidx, 3'b000} +: 8] =
                                    n_cap.timestamp_us[{~n_vidx, 3'b000} +: 8] | b;
                            end else if (n_vidx == 2'd0) begin
                                case (n_tag)
                                    IdxSignal:  n_cap.signal_level   = b;
                                    IdxNoise:   n_cap.noise_level    = b;
                                    IdxRate:    n_cap.data_rate      = b;
                                    IdxKind:    n_cap.frame_kind     = b;
                                    IdxCf:      n_cap.cf_period      = |b;
                                    IdxUndecr:  n_cap.undecrypted    = |b;
                                    IdxFcs:     n_cap.fcs_bad        = |b;
                                    IdxChannel: n_cap.channel_number = b;
                                    default: ;
                                endcase
                            end
                            if (n_vidx == 2'd3) begin
                                n_cdone = 1'b1;
                            end else begin
                                n_vidx = n_vidx + 2'd1;
                            end
                        end
                        n_left = n_left - 8'd1;
                        if (n_left == 8'd0) begin
                            n_phase = PhTag;
                        end
                    end
                    default: ;
                endcase
                if (ended) begin
                    o_fire  = 1'b1;
                    n_phase = PhIdle;
                    if (n_cap.fcs_bad) begin
                        status = sncap_pkg::StatFcs;
                    end else if (n_cap.undecrypted) begin
                        status = sncap_pkg::StatUndecr;
                    end
                end else if (i_item.last_byte) begin
                    o_fire  = 1'b1;
                    n_phase = PhIdle;
                    status  = sncap_pkg::StatNoEnd;
                end
            end
        end
    end

    generate
        if (POSITION_BITS > 16) begin : g_sat
            assign offset = (|n_pos[POSITION_BITS-1:16]) ? 16'hFFFF : n_pos[15:0];
        end else begin : g_ext
            assign offset = 16'(n_pos);
        end
    endgenerate

    always_comb begin
        o_result.version        = n_cap.version;
        o_result.encap_code     = n_cap.encap_code;
        o_result.signal_level   = n_cap.signal_level;
        o_result.noise_level    = n_cap.noise_level;
        o_result.data_rate      = n_cap.data_rate;
        o_result.timestamp_us   = n_cap.timestamp_us;
        o_result.frame_kind     = n_cap.frame_kind;
        o_result.cf_period      = n_cap.cf_period;
        o_result.channel_number = n_cap.channel_number;
        o_result.present_mask   = n_cap.present_mask;
        o_result.payload_offset = offset;
        o_result.frame_status   = status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PhIdle;
            r_pos   <= '0;
            r_tag   <= '0;
            r_left  <= '0;
            r_vidx  <= '0;
            r_cdone <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_tag   <= n_tag;
            r_left  <= n_left;
            r_vidx  <= n_vidx;
            r_cdone <= n_cdone;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cap <= n_cap;
    end

    `SNCAP_ASSERT_NXT(a_idle_after_result, o_fire, r_phase == PhIdle)
    `SNCAP_ASSERT_IMP(a_value_has_bytes, r_phase == PhValue, r_left != 8'd0)
    `SNCAP_ASSERT_IMP(a_tag_in_range, (r_phase == PhLen) || (r_phase == PhValue), r_tag <= IdxLast)
    `SNCAP_ASSERT_IMP(a_header_clean, r_phase == PhHeader, r_cap.present_mask == 9'd0)
    `SNCAP_ASSERT_IMP(a_done_at_end, r_cdone, r_vidx == 2'd3)

endmodule

`default_nettype wire

// ===== rtl/sncap_out_reg.sv =====
`default_nettype none

module sncap_out_reg (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_load,
    input  sncap_pkg::t_result i_result,
    output logic               o_room,
    sncap_res_if.source        o_result
);

    logic               r_vld;
    logic               n_vld;
    sncap_pkg::t_result r_res;

    assign o_room = !r_vld || o_result.ready;

    always_comb begin
        n_vld = r_vld;
        if (i_load) begin
            n_vld = 1'b1;
        end else if (o_result.ready) begin
            n_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_result;
        end
    end

    assign o_result.valid          = r_vld;
    assign o_result.version        = r_res.version;
    assign o_result.encap_code     = r_res.encap_code;
    assign o_result.signal_level   = r_res.signal_level;
    assign o_result.noise_level    = r_res.noise_level;
    assign o_result.data_rate      = r_res.data_rate;
    assign o_result.timestamp_us   = r_res.timestamp_us;
    assign o_result.frame_kind     = r_res.frame_kind;
    assign o_result.cf_period      = r_res.cf_period;
    assign o_result.channel_number = r_res.channel_number;
    assign o_result.present_mask   = r_res.present_mask;
    assign o_result.payload_offset = r_res.payload_offset;
    assign o_result.frame_status   = r_res.frame_status;

endmodule

`default_nettype wire

// ===== rtl/sniffer_encap_option_parser.sv =====
// A result is offered from the output register once the parser has taken the byte that ends its packet.
// Throughput: one byte per cycle while the output register has room for a result.
// The input register is refilled in the same cycle it hands its byte to the parser.
// Reset is synchronous and active low; it empties both registers and idles the parser.
// After reset, bytes are ignored until a byte marked as the first of a packet arrives.
`default_nettype none

module sniffer_encap_option_parser #(
    parameter int POSITION_BITS = 16
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    sncap_byte_if.sink  i_byte,
    sncap_res_if.source o_result
);

    logic                in_vld;
    sncap_pkg::t_in_item in_item;
    logic                room;
    logic                step;
    logic                fire;
    sncap_pkg::t_result  res;

    assign step = in_vld && room;

    sncap_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (i_byte),
        .i_take  (step),
        .o_vld   (in_vld),
        .o_item  (in_item)
    );

    sncap_parse #(
        .POSITION_BITS (POSITION_BITS)
    ) u_parse (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_item   (in_item),
        .o_fire   (fire),
        .o_result (res)
    );

    sncap_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (fire),
        .i_result (res),
        .o_room   (room),
        .o_result (o_result)
    );

endmodule

`default_nettype wire
